// ----- src/cbp_pkg.sv -----
`timescale 1ns / 1ps
// cbp_pkg: shared widths, operation codes and structs for the code/symbol bit packer
// no dependencies; imported by every module of the packer

package cbp_pkg;

  localparam int BYTE_W = 8;
  localparam int CODE_W = 16;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 5;
  localparam int PEND_W = 3;
  // 7 pending + 16 code + 8 symbol bits
  localparam int ACC_W  = 31;
  localparam int GRP_N  = 3;
  localparam int CNT_W  = 2;

  localparam logic OP_PAIR  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // bytes produced by one input word, byte 0 goes out first
  typedef struct packed {
    logic [GRP_N-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]             cnt;
  } cbp_group_t;

  // pending partial byte, bits above pend are always zero
  typedef struct packed {
    logic [BYTE_W-1:0] partial;
    logic [PEND_W-1:0] pend;
  } cbp_state_t;

endpackage

// ----- src/cbp_merge.sv -----
`timescale 1ns / 1ps
// cbp_merge: merges pending bits, code and symbol into whole bytes and keeps the remainder
// a flush emits the partial byte and clears the state; depends on cbp_pkg

module cbp_merge #(
  parameter int MAX_CODE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic                      op,
  input  logic [cbp_pkg::CODE_W-1:0] code,
  input  logic [cbp_pkg::SYM_W-1:0]  sym,
  input  logic [cbp_pkg::LEN_W-1:0]  len,
  output cbp_pkg::cbp_group_t       grp,
  output cbp_pkg::cbp_state_t       st
);
  import cbp_pkg::*;

  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_CODE_BITS);

  logic [LEN_W-1:0]  len_c;
  logic [CODE_W:0]   mask_full;
  logic [CODE_W-1:0] code_m;
  logic [LEN_W-1:0]  sym_sh;
  logic [LEN_W-1:0]  total;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  rest;
  cbp_state_t        st_next;

  always_comb begin
    len_c     = (len > LEN_CAP) ? LEN_CAP : len;
    mask_full = ({{CODE_W{1'b0}}, 1'b1} << len_c) - {{CODE_W{1'b0}}, 1'b1};
    code_m    = code & mask_full[CODE_W-1:0];
    sym_sh    = LEN_W'(st.pend) + len_c;
    total     = sym_sh + LEN_W'(BYTE_W);
    acc       = ACC_W'(st.partial) | (ACC_W'(code_m) << st.pend) | (ACC_W'(sym) << sym_sh);
    // drop the whole bytes, what is left is the new partial byte
    rest      = acc >> {total[LEN_W-1:PEND_W], 3'b000};
  end

  always_comb begin
    if (op == OP_FLUSH) begin
      grp.bytes    = '0;
      grp.bytes[0] = st.partial;
      grp.cnt      = (st.pend != '0) ? CNT_W'(1) : '0;
      st_next      = '0;
    end else begin
      grp.bytes[0]    = acc[BYTE_W-1:0];
      grp.bytes[1]    = acc[2*BYTE_W-1:BYTE_W];
      grp.bytes[2]    = acc[3*BYTE_W-1:2*BYTE_W];
      grp.cnt         = total[LEN_W-1:PEND_W];
      st_next.partial = rest[BYTE_W-1:0];
      st_next.pend    = total[PEND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (load) begin
      st <= st_next;
    end
  end

endmodule

// ----- src/cbp_emitter.sv -----
`timescale 1ns / 1ps
// cbp_emitter: holds one input word's bytes, sends one per cycle while m_tready is high
// depends on cbp_pkg

module cbp_emitter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  cbp_pkg::cbp_group_t        grp,
  output logic                       can_load,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [cbp_pkg::BYTE_W-1:0] m_tdata,
  output logic                       m_tlast
);
  import cbp_pkg::*;

  logic [GRP_N-1:0][BYTE_W-1:0] hold;
  logic [CNT_W-1:0]             cnt;
  logic                         take;

  assign m_tvalid = (cnt != '0);
  assign m_tdata  = hold[0];
  assign m_tlast  = (cnt == CNT_W'(1));
  assign take     = m_tvalid && m_tready;
  // a new group may enter while the last byte of the old one is taken
  assign can_load = (cnt == '0) || (m_tlast && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load && can_load) begin
      cnt <= grp.cnt;
    end else if (take) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      hold <= grp.bytes;
    end else if (take) begin
      hold <= {{BYTE_W{1'b0}}, hold[GRP_N-1:1]};
    end
  end

endmodule

// ----- src/code_symbol_bit_packer_core.sv -----
`timescale 1ns / 1ps
// code_symbol_bit_packer_core: top level of the lsb-first code/symbol byte packer
// depends on cbp_pkg, cbp_merge and cbp_emitter

// usage
//   slave channel: one word per pair or flush; s_tuser selects the operation
//   (0 append pair, 1 flush), s_tdata carries code, symbol and code length
//   master channel: one packed byte per word, earliest bit in bit 0; m_tlast
//   marks the final byte caused by one input word
//   a pair yields one to three bytes, a flush one byte or none (nothing pending)
// path: an accepted word is held in the input register; its first byte then shows on
//   m_tvalid from the byte holding register feeding m_tdata
// throughput: one input word per cycle while each word makes a single byte and
//   m_tready is high; a word making n bytes occupies the byte holding register
//   until all n are taken, since the output port carries one byte per transfer
// stalls: while m_tready is low the held byte stays; the input register takes
//   one more word, then s_tready drops until the holding register frees up
// reset: rst clears the pending bits, the input register and the output
//   stage; no word is presented after reset until new input arrives

module code_symbol_bit_packer_core #(
  parameter int MAX_CODE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,   // code_value[15:0], symbol[23:16], code_length[28:24]
  input  logic                       s_tuser,   // operation
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [cbp_pkg::BYTE_W-1:0] m_tdata,   // data_byte[7:0]
  output logic                       m_tlast    // last_of_run
);
  import cbp_pkg::*;

  // input register
  logic              in_valid;
  logic              in_op;
  logic [CODE_W-1:0] in_code;
  logic [SYM_W-1:0]  in_sym;
  logic [LEN_W-1:0]  in_len;

  logic       s_fire;
  logic       load;
  logic       emit_ready;
  cbp_group_t grp;
  cbp_state_t st;

  assign s_fire   = s_tvalid && s_tready;
  assign load     = in_valid && emit_ready;
  assign s_tready = !in_valid || emit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_op   <= s_tuser;
      in_code <= s_tdata[CODE_W-1:0];
      in_sym  <= s_tdata[CODE_W+SYM_W-1:CODE_W];
      in_len  <= s_tdata[CODE_W+SYM_W+LEN_W-1:CODE_W+SYM_W];
    end
  end

  // bit merge and pending state
  cbp_merge #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_merge (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .op   (in_op),
    .code (in_code),
    .sym  (in_sym),
    .len  (in_len),
    .grp  (grp),
    .st   (st)
  );

  // byte serializer and output register
  cbp_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .grp      (grp),
    .can_load (emit_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // a flush always leaves nothing pending
  assert property (@(posedge clk) disable iff (rst)
    load && (in_op == OP_FLUSH) |=> (st.pend == '0) && (st.partial == '0))
    else $error("pending bits left after flush");

  // partial byte never holds bits above the pending count
  assert property (@(posedge clk) disable iff (rst)
    (st.partial >> st.pend) == '0)
    else $error("stray bits above pending count");

  // a pair always completes at least one byte
  assert property (@(posedge clk) disable iff (rst)
    load && (in_op == OP_PAIR) |-> (grp.cnt != '0))
    else $error("pair produced no byte");

  // input side stalls only behind a full input register
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && !emit_ready)
    else $error("input stalled without cause");

  // last byte taken with nothing new leaves the output empty
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast && !load |=> !m_tvalid)
    else $error("output valid after final byte");

endmodule
